[design/fpcp_pkg.sv]
// ----------------------------------------------------------------------------
// fpcp_pkg: shared types, codes and tables for the camera pose keeper
// Request and direction codes, register indexes, sequencer states,
// fixed-point angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpcp_pkg;

  // Request codes
  localparam logic [1:0] REQ_MOVE = 2'd0;
  localparam logic [1:0] REQ_LOOK = 2'd1;
  localparam logic [1:0] REQ_SET  = 2'd2;

  // Move directions
  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_SENS  = 3'd0;
  localparam logic [2:0] CFG_SPEED = 3'd1;
  localparam logic [2:0] CFG_FLY   = 3'd2;
  localparam logic [2:0] CFG_WUX   = 3'd3;
  localparam logic [2:0] CFG_WUY   = 3'd4;
  localparam logic [2:0] CFG_WUZ   = 3'd5;

  // Angle constants, Q16.16 degrees
  localparam int DEG90     = 5898240;
  localparam int DEG180    = 11796480;
  localparam int DEG360    = 23592960;
  localparam int PITCH_LIM = 5832704;

  // CORDIC gain at 30 fraction bits
  localparam int CORDIC_GAIN = 652032874;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef enum logic [4:0] {
    S_IDLE, S_MVEL, S_MSEL, S_MAPPLY, S_LOOK, S_WRAP, S_CINIT, S_CORD,
    S_CEND, S_FRONT, S_NHALF, S_NSQ, S_NCHK, S_NROOT, S_DINIT, S_DIV,
    S_DEND, S_NEND, S_CROSS, S_DONE
  } state_e;

  // Where a normalized vector goes
  typedef enum logic [1:0] {
    NT_HFRONT, NT_FRONT, NT_RIGHT, NT_UP
  } norm_tgt_e;

  // arctan(2^-i) in Q16.16 degrees
  function automatic logic signed [25:0] atan_deg(input logic [4:0] i);
    logic signed [25:0] r;
    case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117266;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  // Cross product operand order: o[k] = a[p]b[q] - a[q]b[p]
  function automatic logic [1:0] cr_a_idx(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0: r = 2'd1;
      3'd1: r = 2'd2;
      3'd2: r = 2'd2;
      3'd3: r = 2'd0;
      3'd4: r = 2'd0;
      3'd5: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cr_b_idx(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0: r = 2'd2;
      3'd1: r = 2'd1;
      3'd2: r = 2'd0;
      3'd3: r = 2'd2;
      3'd4: r = 2'd1;
      3'd5: r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] pick16(input logic signed [15:0] v0,
                                                input logic signed [15:0] v1,
                                                input logic signed [15:0] v2,
                                                input logic [1:0] i);
    logic signed [15:0] r;
    case (i)
      2'd1:    r = v1;
      2'd2:    r = v2;
      default: r = v0;
    endcase
    return r;
  endfunction

  function automatic logic signed [33:0] pick34(input logic signed [33:0] v0,
                                                input logic signed [33:0] v1,
                                                input logic signed [33:0] v2,
                                                input logic [1:0] i);
    logic signed [33:0] r;
    case (i)
      2'd1:    r = v1;
      2'd2:    r = v2;
      default: r = v0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] clamp_pitch(input logic signed [29:0] p);
    logic signed [23:0] r;
    if (p > 30'(PITCH_LIM)) begin
      r = 24'(PITCH_LIM);
    end else if (p < -30'(PITCH_LIM)) begin
      r = -24'(PITCH_LIM);
    end else begin
      r = 24'(p);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // Magnitude at or above 2^30
  function automatic logic big30(input logic signed [33:0] v);
    return (v >= 34'sd1073741824) || (v <= -34'sd1073741824);
  endfunction

endpackage

[design/first_person_camera_pose.sv]
// ----------------------------------------------------------------------------
// first_person_camera_pose: fixed-point first-person camera pose keeper
// Work per item: a move right/up applies directly, forward/back after one
// normalization; look and set-pose do a yaw wrap, two CORDIC runs of
// CORDIC_STEPS steps and three normalizations, each a 32-step square root
// and three 16-step divides. One item at a time.
// Reset: pose goes to origin, zero angles, front +x, right +z, up +y.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_person_camera_pose #(
  parameter int CORDIC_STEPS = fpcp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic [2:0]          direction_i,
  input  logic [15:0]         delta_time_i,
  input  logic signed [15:0]  x_offset_i,
  input  logic signed [15:0]  y_offset_i,
  input  logic                can_go_up_i,
  input  logic                can_go_down_i,
  input  logic signed [31:0]  set_pos_x_i,
  input  logic signed [31:0]  set_pos_y_i,
  input  logic signed [31:0]  set_pos_z_i,
  input  logic signed [24:0]  set_yaw_i,
  input  logic signed [23:0]  set_pitch_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic signed [15:0]  front_x_o,
  output logic signed [15:0]  front_y_o,
  output logic signed [15:0]  front_z_o,
  output logic signed [15:0]  right_x_o,
  output logic signed [15:0]  right_y_o,
  output logic signed [15:0]  right_z_o,
  output logic signed [15:0]  up_x_o,
  output logic signed [15:0]  up_y_o,
  output logic signed [15:0]  up_z_o
);
  import fpcp_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  // Sequencer
  state_e state_q, state_d;
  logic [4:0] cnt_q;
  logic       in_acc, out_load, out_valid_q;

  // Configuration
  logic [15:0]        sens_q, speed_q;
  logic               fly_q;
  logic signed [15:0] wu_q [3];

  // Architectural pose
  logic signed [31:0] pos_q [3];
  logic signed [24:0] yaw_q;
  logic signed [23:0] pitch_q;
  logic signed [15:0] fv_q [3];
  logic signed [15:0] rv_q [3];
  logic signed [15:0] uv_q [3];

  // Latched item
  logic [2:0]         dir_q;
  logic [15:0]        dt_q;
  logic signed [15:0] xo_q, yo_q;
  logic               cgu_q, cgd_q;

  // Work registers
  logic [23:0]        vel_q;
  logic signed [15:0] mvec_q [3];
  logic               sub_q;
  logic signed [29:0] wrap_q;
  logic               phase_q, neg_q, cross_sel_q;
  logic signed [33:0] cx_q, cy_q_r, sy_q, cyw_q, sp_q, cp_q;
  logic signed [25:0] ca_q;
  logic signed [33:0] nv_q [3];
  logic signed [15:0] nres_q [3];
  norm_tgt_e          tgt_q;
  logic [61:0]        len_q, rem_q;
  logic [62:0]        res_q, bit_q;
  logic [47:0]        dnum_q;
  logic [15:0]        qt_q;
  logic [1:0]         nk_q;

  // Shared multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod_q;

  // Output registers
  logic signed [31:0] opos_q [3];
  logic signed [15:0] ofv_q [3];
  logic signed [15:0] orv_q [3];
  logic signed [15:0] ouv_q [3];

  // Derived values
  logic signed [67:0] rnd14, rnd4;
  logic signed [33:0] mv_d;
  logic signed [29:0] ang_d;
  logic signed [33:0] mv_sum;
  logic signed [31:0] pos_cur;
  logic               any_big;
  logic [62:0]        trial;
  logic [48:0]        den_sh;
  logic signed [33:0] nv_sel;
  logic [29:0]        nv_abs;
  logic [15:0]        q_cl;
  logic signed [25:0] cin_a;
  logic               go_vert;
  logic [2:0]         cj;

  assign in_acc = in_valid_i && (state_q == S_IDLE);

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  always_comb begin
    rnd14   = prod_q + 68'sd8192;
    rnd4    = prod_q + 68'sd8;
    mv_d    = 34'(rnd14 >>> 14);
    ang_d   = 30'(rnd4 >>> 4);
    pos_cur = pos_q[0];
    case (cnt_q)
      5'd2:    pos_cur = pos_q[1];
      5'd3:    pos_cur = pos_q[2];
      default: pos_cur = pos_q[0];
    endcase
    mv_sum  = sub_q ? (34'(pos_cur) - mv_d) : (34'(pos_cur) + mv_d);
    any_big = big30(nv_q[0]) || big30(nv_q[1]) || big30(nv_q[2]);
    trial   = res_q + bit_q;
    den_sh  = 49'({res_q[31:0], 1'b0}) << cnt_q[3:0];
    nv_sel  = pick34(nv_q[0], nv_q[1], nv_q[2], nk_q);
    nv_abs  = nv_sel[33] ? 30'(-nv_sel) : 30'(nv_sel);
    q_cl    = (qt_q > 16'd32767) ? 16'd32767 : qt_q;
    cin_a   = phase_q ? 26'(pitch_q) : 26'(yaw_q);
    go_vert = fly_q && ((dir_q == DIR_UP) ? cgu_q : cgd_q);
    cj      = cnt_q[2:0];
  end

  // Multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_MVEL: begin
        ma = signed'(34'(speed_q));
        mb = signed'(34'(dt_q));
      end
      S_MAPPLY: begin
        ma = signed'(34'(vel_q));
        mb = 34'(pick16(mvec_q[0], mvec_q[1], mvec_q[2],
                        (cnt_q < 5'd3) ? cnt_q[1:0] : 2'd0));
      end
      S_LOOK: begin
        ma = signed'(34'(sens_q));
        mb = (cnt_q == 5'd0) ? 34'(xo_q) : 34'(yo_q);
      end
      S_FRONT: begin
        ma = (cnt_q == 5'd0) ? cyw_q : sy_q;
        mb = cp_q;
      end
      S_NSQ: begin
        ma = pick34(nv_q[0], nv_q[1], nv_q[2], (cnt_q < 5'd3) ? cnt_q[1:0] : 2'd0);
        mb = ma;
      end
      S_CROSS: begin
        if (cross_sel_q) begin
          ma = 34'(pick16(rv_q[0], rv_q[1], rv_q[2], cr_a_idx(cj)));
          mb = 34'(pick16(fv_q[0], fv_q[1], fv_q[2], cr_b_idx(cj)));
        end else begin
          ma = 34'(pick16(fv_q[0], fv_q[1], fv_q[2], cr_a_idx(cj)));
          mb = 34'(pick16(wu_q[0], wu_q[1], wu_q[2], cr_b_idx(cj)));
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_MOVE: state_d = S_MVEL;
            REQ_LOOK: state_d = S_LOOK;
            REQ_SET:  state_d = S_WRAP;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_MVEL: state_d = S_MSEL;
      S_MSEL: begin
        case (dir_q)
          DIR_FWD, DIR_BACK:   state_d = S_NHALF;
          DIR_LEFT, DIR_RIGHT: state_d = S_MAPPLY;
          DIR_UP, DIR_DOWN:    state_d = go_vert ? S_MAPPLY : S_DONE;
          default:             state_d = S_DONE;
        endcase
      end
      S_MAPPLY: if (cnt_q == 5'd3) state_d = S_DONE;
      S_LOOK:   if (cnt_q == 5'd2) state_d = S_WRAP;
      S_WRAP: begin
        if (wrap_q >= 30'(DEG360) || wrap_q < 30'sd0) begin
          state_d = S_WRAP;
        end else begin
          state_d = S_CINIT;
        end
      end
      S_CINIT:  state_d = S_CORD;
      S_CORD:   if (cnt_q == LAST_STEP) state_d = S_CEND;
      S_CEND:   state_d = phase_q ? S_FRONT : S_CINIT;
      S_FRONT:  if (cnt_q == 5'd2) state_d = S_NHALF;
      S_NHALF:  if (!any_big) state_d = S_NSQ;
      S_NSQ:    if (cnt_q == 5'd3) state_d = S_NCHK;
      S_NCHK:   state_d = (len_q == '0) ? S_NEND : S_NROOT;
      S_NROOT:  if (cnt_q == 5'd31) state_d = S_DINIT;
      S_DINIT:  state_d = S_DIV;
      S_DIV:    if (cnt_q == 5'd0) state_d = S_DEND;
      S_DEND:   state_d = (nk_q == 2'd2) ? S_NEND : S_DINIT;
      S_NEND: begin
        case (tgt_q)
          NT_HFRONT: state_d = S_MAPPLY;
          NT_UP:     state_d = S_DONE;
          default:   state_d = S_CROSS;
        endcase
      end
      S_CROSS:  if (cnt_q == 5'd6) state_d = S_NHALF;
      S_DONE:   if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q  <= 16'd3932;
      speed_q <= 16'd2560;
      fly_q   <= 1'b1;
      wu_q[0] <= 16'sd0;
      wu_q[1] <= ONE_Q14;
      wu_q[2] <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_SENS:  sens_q  <= cfg_wdata_i;
        CFG_SPEED: speed_q <= cfg_wdata_i;
        CFG_FLY:   fly_q   <= cfg_wdata_i[0];
        CFG_WUX:   wu_q[0] <= signed'(cfg_wdata_i);
        CFG_WUY:   wu_q[1] <= signed'(cfg_wdata_i);
        CFG_WUZ:   wu_q[2] <= signed'(cfg_wdata_i);
        default:   ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pose state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      yaw_q    <= '0;
      pitch_q  <= '0;
      fv_q[0]  <= ONE_Q14;
      fv_q[1]  <= '0;
      fv_q[2]  <= '0;
      rv_q[0]  <= '0;
      rv_q[1]  <= '0;
      rv_q[2]  <= ONE_Q14;
      uv_q[0]  <= '0;
      uv_q[1]  <= ONE_Q14;
      uv_q[2]  <= '0;
    end else begin
      // set-pose loads position and pitch at the transfer
      if (in_acc && req_type_i == REQ_SET) begin
        pos_q[0] <= set_pos_x_i;
        pos_q[1] <= set_pos_y_i;
        pos_q[2] <= set_pos_z_i;
        pitch_q  <= clamp_pitch(30'(set_pitch_i));
      end
      if (state_q == S_MAPPLY) begin
        case (cnt_q)
          5'd1:    pos_q[0] <= sat32(mv_sum);
          5'd2:    pos_q[1] <= sat32(mv_sum);
          5'd3:    pos_q[2] <= sat32(mv_sum);
          default: ;
        endcase
      end
      if (state_q == S_LOOK && cnt_q == 5'd2) begin
        pitch_q <= clamp_pitch(30'(pitch_q) + ang_d);
      end
      if (state_q == S_WRAP && state_d == S_CINIT) begin
        yaw_q <= 25'(wrap_q - 30'(DEG180));
      end
      if (state_q == S_NEND) begin
        case (tgt_q)
          NT_FRONT: fv_q <= nres_q;
          NT_RIGHT: rv_q <= nres_q;
          NT_UP:    uv_q <= nres_q;
          default:  ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Work datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // step counter restarts on each state change; the divide instead starts it at 15 and counts down
    cnt_q <= (state_d == state_q) ? cnt_q + 5'd1 : 5'd0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          dir_q  <= direction_i;
          dt_q   <= delta_time_i;
          xo_q   <= x_offset_i;
          yo_q   <= y_offset_i;
          cgu_q  <= can_go_up_i;
          cgd_q  <= can_go_down_i;
          wrap_q <= 30'(set_yaw_i) + 30'(DEG180);
        end
      end
      S_MSEL: begin
        vel_q <= prod_q[31:8];
        case (dir_q)
          DIR_FWD, DIR_BACK: begin
            nv_q[0] <= 34'(fv_q[0]);
            nv_q[1] <= '0;
            nv_q[2] <= 34'(fv_q[2]);
            tgt_q   <= NT_HFRONT;
            sub_q   <= (dir_q == DIR_BACK);
          end
          DIR_LEFT, DIR_RIGHT: begin
            mvec_q <= rv_q;
            sub_q  <= (dir_q == DIR_LEFT);
          end
          default: begin
            mvec_q <= wu_q;
            sub_q  <= (dir_q == DIR_DOWN);
          end
        endcase
      end
      S_LOOK: begin
        if (cnt_q == 5'd1) begin
          wrap_q <= 30'(yaw_q) + ang_d + 30'(DEG180);
        end
      end
      S_WRAP: begin
        // bring yaw + 180 into [0, 360)
        if (wrap_q >= 30'(DEG360)) begin
          wrap_q <= wrap_q - 30'(DEG360);
        end else if (wrap_q < 30'sd0) begin
          wrap_q <= wrap_q + 30'(DEG360);
        end
        phase_q <= 1'b0;
      end
      S_CINIT: begin
        // fold into +-90 degrees, negate results later
        if (cin_a > 26'(DEG90)) begin
          ca_q  <= cin_a - 26'(DEG180);
          neg_q <= 1'b1;
        end else if (cin_a < -26'(DEG90)) begin
          ca_q  <= cin_a + 26'(DEG180);
          neg_q <= 1'b1;
        end else begin
          ca_q  <= cin_a;
          neg_q <= 1'b0;
        end
        cx_q   <= 34'(CORDIC_GAIN);
        cy_q_r <= '0;
      end
      S_CORD: begin
        if (!ca_q[25]) begin
          cx_q   <= cx_q - (cy_q_r >>> cnt_q);
          cy_q_r <= cy_q_r + (cx_q >>> cnt_q);
          ca_q   <= ca_q - atan_deg(cnt_q);
        end else begin
          cx_q   <= cx_q + (cy_q_r >>> cnt_q);
          cy_q_r <= cy_q_r - (cx_q >>> cnt_q);
          ca_q   <= ca_q + atan_deg(cnt_q);
        end
      end
      S_CEND: begin
        if (phase_q) begin
          sp_q <= neg_q ? -cy_q_r : cy_q_r;
          cp_q <= neg_q ? -cx_q : cx_q;
        end else begin
          sy_q  <= neg_q ? -cy_q_r : cy_q_r;
          cyw_q <= neg_q ? -cx_q : cx_q;
        end
        phase_q <= 1'b1;
      end
      S_FRONT: begin
        if (cnt_q == 5'd1) begin
          nv_q[0] <= 34'(prod_q >>> 30);
        end
        if (cnt_q == 5'd2) begin
          nv_q[2] <= 34'(prod_q >>> 30);
          nv_q[1] <= sp_q;
          tgt_q   <= NT_FRONT;
        end
      end
      S_NHALF: begin
        if (any_big) begin
          nv_q[0] <= nv_q[0] >>> 1;
          nv_q[1] <= nv_q[1] >>> 1;
          nv_q[2] <= nv_q[2] >>> 1;
        end
      end
      S_NSQ: begin
        // sum of squares, one term per cycle
        if (cnt_q == 5'd1) begin
          len_q <= prod_q[61:0];
        end else if (cnt_q != 5'd0) begin
          len_q <= len_q + prod_q[61:0];
        end
      end
      S_NCHK: begin
        rem_q  <= len_q;
        res_q  <= '0;
        bit_q  <= 63'(1) << 62;
        nk_q   <= 2'd0;
        nres_q[0] <= '0;
        nres_q[1] <= '0;
        nres_q[2] <= '0;
      end
      S_NROOT: begin
        // bit-pair integer square root
        if ({1'b0, rem_q} >= trial) begin
          rem_q <= rem_q - trial[61:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DINIT: begin
        dnum_q <= (48'(nv_abs) << 15) + 48'(res_q[31:0]);
        qt_q   <= '0;
        cnt_q  <= 5'd15;
      end
      S_DIV: begin
        // restoring divide by twice the root
        if ({1'b0, dnum_q} >= den_sh) begin
          dnum_q <= dnum_q - den_sh[47:0];
          qt_q[cnt_q[3:0]] <= 1'b1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
      S_DEND: begin
        case (nk_q)
          2'd0:    nres_q[0] <= nv_sel[33] ? -signed'(q_cl) : signed'(q_cl);
          2'd1:    nres_q[1] <= nv_sel[33] ? -signed'(q_cl) : signed'(q_cl);
          default: nres_q[2] <= nv_sel[33] ? -signed'(q_cl) : signed'(q_cl);
        endcase
        nk_q <= nk_q + 2'd1;
      end
      S_NEND: begin
        case (tgt_q)
          NT_HFRONT: mvec_q <= nres_q;
          NT_FRONT:  cross_sel_q <= 1'b0;
          NT_RIGHT:  cross_sel_q <= 1'b1;
          default:   ;
        endcase
      end
      S_CROSS: begin
        // accumulate one product per cycle into the cross result
        case (cnt_q)
          5'd1: nv_q[0] <= 34'(prod_q);
          5'd2: nv_q[0] <= nv_q[0] - 34'(prod_q);
          5'd3: nv_q[1] <= 34'(prod_q);
          5'd4: nv_q[1] <= nv_q[1] - 34'(prod_q);
          5'd5: nv_q[2] <= 34'(prod_q);
          5'd6: begin
            nv_q[2] <= nv_q[2] - 34'(prod_q);
            tgt_q   <= cross_sel_q ? NT_UP : NT_RIGHT;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      opos_q <= pos_q;
      ofv_q  <= fv_q;
      orv_q  <= rv_q;
      ouv_q  <= uv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = opos_q[0];
  assign pos_y_o     = opos_q[1];
  assign pos_z_o     = opos_q[2];
  assign front_x_o   = ofv_q[0];
  assign front_y_o   = ofv_q[1];
  assign front_z_o   = ofv_q[2];
  assign right_x_o   = orv_q[0];
  assign right_y_o   = orv_q[1];
  assign right_z_o   = orv_q[2];
  assign up_x_o      = ouv_q[0];
  assign up_y_o      = ouv_q[1];
  assign up_z_o      = ouv_q[2];

endmodule

[tb/first_person_camera_pose_test.sv]
// ----------------------------------------------------------------------------
// first_person_camera_pose_test: self-checking bench for the camera pose keeper
// A directed table, then random moves, looks and pose loads across several
// register settings. A fixed-point model predicts each pose but the first two;
// both channels idle and stall at random, with one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_person_camera_pose_test;
  import fpcp_pkg::*;

  localparam int  RND_PER_PHASE = 145;
  localparam int  CYCLE_LIMIT   = 2000000;
  localparam int  DRAIN_CYCLES  = 400;
  localparam int  HOLD_CYCLES   = 700;
  localparam int  NSTEPS        = CORDIC_STEPS_DEF;
  localparam longint ONE30      = 64'sd1073741824;

  // arctan(2^-i) in Q16.16 degrees
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  typedef struct packed {
    logic signed [63:0] x, y, z;
  } wide_vec_t;

  typedef struct packed {
    logic signed [15:0] x, y, z;
  } unit_vec_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    unit_vec_t          front, right, up;
  } pose_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         dir;
    logic [15:0]        dt;
    logic signed [15:0] xo, yo;
    logic               go_up, go_down;
    logic signed [31:0] spx, spy, spz;
    logic signed [24:0] syaw;
    logic signed [23:0] spitch;
    logic               fixed_exp;
  } cam_req_t;

  localparam pose_t RESET_POSE = '{px: 0, py: 0, pz: 0,
                                   front: '{16'sd16384, 16'sd0, 16'sd0},
                                   right: '{16'sd0, 16'sd0, 16'sd16384},
                                   up: '{16'sd0, 16'sd16384, 16'sd0}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [2:0] direction_i = '0;
  logic [15:0] delta_time_i = '0;
  logic signed [15:0] x_offset_i = '0, y_offset_i = '0;
  logic can_go_up_i = 1'b0, can_go_down_i = 1'b0;
  logic signed [31:0] set_pos_x_i = '0, set_pos_y_i = '0, set_pos_z_i = '0;
  logic signed [24:0] set_yaw_i = '0;
  logic signed [23:0] set_pitch_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pose_t got;

  first_person_camera_pose u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .req_type_i, .direction_i, .delta_time_i,
    .x_offset_i, .y_offset_i, .can_go_up_i, .can_go_down_i,
    .set_pos_x_i, .set_pos_y_i, .set_pos_z_i, .set_yaw_i, .set_pitch_i,
    .out_valid_o, .out_stall_i,
    .pos_x_o(got.px), .pos_y_o(got.py), .pos_z_o(got.pz),
    .front_x_o(got.front.x), .front_y_o(got.front.y), .front_z_o(got.front.z),
    .right_x_o(got.right.x), .right_y_o(got.right.y), .right_z_o(got.right.z),
    .up_x_o(got.up.x), .up_y_o(got.up.y), .up_z_o(got.up.z)
  );

  always #1 clk_i = ~clk_i;

  // Model state: registers and pose
  logic [15:0] m_sens, m_speed;
  logic        m_fly;
  unit_vec_t   m_wup;
  logic signed [31:0] m_pos [3];
  longint      m_yaw, m_pitch;
  unit_vec_t   m_front, m_right, m_up;

  pose_t pose_q[$];
  int    n_err = 0;
  int    n_sent = 0;
  int    n_got = 0;
  int    idle_mode = 0;     // 0: sender light/receiver heavy, 1: swapped, 2: none
  int    hold_reqs = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    cycles = 0;

  // ---------------------------------------------------------------- model
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic unit_vec_t to_unit(wide_vec_t w);
    longint v [3];
    longint unsigned len2, r, q;
    unit_vec_t o;
    logic signed [15:0] c [3];
    v[0] = w.x; v[1] = w.y; v[2] = w.z;
    while (absl(v[0]) >= ONE30 || absl(v[1]) >= ONE30 || absl(v[2]) >= ONE30)
      for (int k = 0; k < 3; k++) v[k] = v[k] >>> 1;
    len2 = 0;
    for (int k = 0; k < 3; k++) len2 += longint'(v[k] * v[k]);
    if (len2 == 0) return '0;
    r = root64(len2);
    for (int k = 0; k < 3; k++) begin
      q = (longint'(absl(v[k])) * 32768 + r) / (2 * r);
      if (q > 32767) q = 32767;
      c[k] = (v[k] < 0) ? -16'(q) : 16'(q);
    end
    o.x = c[0]; o.y = c[1]; o.z = c[2];
    return o;
  endfunction

  function automatic wide_vec_t cross_of(unit_vec_t a, unit_vec_t b);
    wide_vec_t o;
    o.x = longint'(a.y) * b.z - longint'(a.z) * b.y;
    o.y = longint'(a.z) * b.x - longint'(a.x) * b.z;
    o.z = longint'(a.x) * b.y - longint'(a.y) * b.x;
    return o;
  endfunction

  // Rotation-mode CORDIC, 30 fraction bits, folded beyond +-90 degrees
  task automatic sin_cos(input longint a, output longint s, output longint c);
    longint x, y, nx;
    bit flip;
    x = CORDIC_GAIN; y = 0; flip = 0;
    if (a > DEG90) begin
      a -= DEG180; flip = 1;
    end else if (a < -DEG90) begin
      a += DEG180; flip = 1;
    end
    for (int i = 0; i < NSTEPS && i < 24; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); a -= ATAN_Q16[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); a += ATAN_Q16[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint wrap_deg(longint y);
    longint w;
    w = (y + DEG180) % DEG360;
    if (w < 0) w += DEG360;
    return w - DEG180;
  endfunction

  function automatic longint limit_pitch(longint p);
    if (p > PITCH_LIM) return PITCH_LIM;
    if (p < -PITCH_LIM) return -PITCH_LIM;
    return p;
  endfunction

  task automatic rebuild_axes();
    longint sy, cy, sp, cp;
    wide_vec_t f;
    sin_cos(m_yaw, sy, cy);
    sin_cos(m_pitch, sp, cp);
    f.x = (cy * cp) >>> 30;
    f.y = sp;
    f.z = (sy * cp) >>> 30;
    m_front = to_unit(f);
    m_right = to_unit(cross_of(m_front, m_wup));
    m_up = to_unit(cross_of(m_right, m_front));
  endtask

  task automatic camera_reset();
    m_sens = 16'd3932; m_speed = 16'd2560; m_fly = 1'b1;
    m_wup = '{16'sd0, ONE_Q14, 16'sd0};
    for (int k = 0; k < 3; k++) m_pos[k] = 0;
    m_yaw = 0; m_pitch = 0;
    m_front = RESET_POSE.front; m_right = RESET_POSE.right; m_up = RESET_POSE.up;
  endtask

  // Apply one request to the model and return the pose after it
  task automatic camera_step(input cam_req_t it, output pose_t p);
    longint vel, d, t;
    unit_vec_t dv;
    wide_vec_t h;
    bit go, neg;
    longint c [3];
    case (it.kind)
      REQ_MOVE: begin
        vel = (longint'(m_speed) * longint'(it.dt)) >>> 8;
        go = 1; neg = 0; dv = '0;
        if (it.dir == DIR_FWD || it.dir == DIR_BACK) begin
          h.x = m_front.x; h.y = 0; h.z = m_front.z;
          dv = to_unit(h); neg = (it.dir == DIR_BACK);
        end else if (it.dir == DIR_LEFT || it.dir == DIR_RIGHT) begin
          dv = m_right; neg = (it.dir == DIR_LEFT);
        end else if (it.dir == DIR_UP || it.dir == DIR_DOWN) begin
          dv = m_wup; neg = (it.dir == DIR_DOWN);
          go = m_fly && ((it.dir == DIR_UP) ? it.go_up : it.go_down);
        end else begin
          go = 0;
        end
        c[0] = dv.x; c[1] = dv.y; c[2] = dv.z;
        if (go)
          for (int k = 0; k < 3; k++) begin
            d = (vel * c[k] + 8192) >>> 14;
            t = longint'(m_pos[k]) + (neg ? -d : d);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            m_pos[k] = 32'(t);
          end
      end
      REQ_LOOK: begin
        m_yaw = wrap_deg(m_yaw + ((longint'(it.xo) * longint'(m_sens) + 8) >>> 4));
        m_pitch = limit_pitch(m_pitch + ((longint'(it.yo) * longint'(m_sens) + 8) >>> 4));
        rebuild_axes();
      end
      REQ_SET: begin
        m_pos[0] = it.spx; m_pos[1] = it.spy; m_pos[2] = it.spz;
        m_yaw = wrap_deg(longint'(it.syaw));
        m_pitch = limit_pitch(longint'(it.spitch));
        rebuild_axes();
      end
      default: ;
    endcase
    p.px = m_pos[0]; p.py = m_pos[1]; p.pz = m_pos[2];
    p.front = m_front; p.right = m_right; p.up = m_up;
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report(input string fld, input longint g, input longint e);
    $display("mismatch #%0d result %0d %s: got %0d expected %0d", n_err, n_got, fld, g, e);
    n_err++;
  endtask

  always @(posedge clk_i) begin
    pose_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pose_q.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        e = pose_q.pop_front();
        if (got.px !== e.px) report("pos_x", got.px, e.px);
        if (got.py !== e.py) report("pos_y", got.py, e.py);
        if (got.pz !== e.pz) report("pos_z", got.pz, e.pz);
        if (got.front.x !== e.front.x) report("front_x", got.front.x, e.front.x);
        if (got.front.y !== e.front.y) report("front_y", got.front.y, e.front.y);
        if (got.front.z !== e.front.z) report("front_z", got.front.z, e.front.z);
        if (got.right.x !== e.right.x) report("right_x", got.right.x, e.right.x);
        if (got.right.y !== e.right.y) report("right_y", got.right.y, e.right.y);
        if (got.right.z !== e.right.z) report("right_z", got.right.z, e.right.z);
        if (got.up.x !== e.up.x) report("up_x", got.up.x, e.up.x);
        if (got.up.y !== e.up.y) report("up_y", got.up.y, e.up.y);
        if (got.up.z !== e.up.z) report("up_z", got.up.z, e.up.z);
      end
      n_got <= n_got + 1;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pose_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      case (idle_mode)
        0: out_stall_i <= ($urandom_range(99) < 65);
        1: out_stall_i <= ($urandom_range(99) < 11);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic cam_req_t mk(logic [1:0] kind, logic [2:0] dir, logic [15:0] dt,
                                  logic signed [15:0] xo, logic signed [15:0] yo,
                                  logic up, logic dn, logic signed [31:0] px,
                                  logic signed [31:0] py, logic signed [31:0] pz,
                                  logic signed [24:0] yaw, logic signed [23:0] pitch);
    cam_req_t r;
    r.kind = kind; r.dir = dir; r.dt = dt; r.xo = xo; r.yo = yo;
    r.go_up = up; r.go_down = dn; r.spx = px; r.spy = py; r.spz = pz;
    r.syaw = yaw; r.spitch = pitch; r.fixed_exp = 1'b0;
    return r;
  endfunction

  function automatic cam_req_t random_req();
    cam_req_t r;
    int pick;
    r = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 45) r.kind = REQ_MOVE;
    else if (pick < 72) r.kind = REQ_LOOK;
    else if (pick < 95) r.kind = REQ_SET;
    else r.kind = 2'd3;
    // mostly short frame times and modest mouse deltas
    if ($urandom_range(3) != 0) r.dt = $urandom_range(4000);
    if ($urandom_range(3) != 0) begin
      r.xo = $signed(16'($urandom_range(800))) - 16'sd400;
      r.yo = $signed(16'($urandom_range(800))) - 16'sd400;
    end
    if ($urandom_range(1)) r.syaw = $signed(25'($urandom_range(23592959))) - 25'sd11796480;
    return r;
  endfunction

  // One transfer; starts at a falling edge, ends at the accepting rising edge
  task automatic send(input cam_req_t it);
    pose_t p;
    @(negedge clk_i);
    while ((idle_mode == 0 && $urandom_range(99) < 11) ||
           (idle_mode == 1 && $urandom_range(99) < 65)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= it.kind; direction_i <= it.dir; delta_time_i <= it.dt;
    x_offset_i <= it.xo; y_offset_i <= it.yo;
    can_go_up_i <= it.go_up; can_go_down_i <= it.go_down;
    set_pos_x_i <= it.spx; set_pos_y_i <= it.spy; set_pos_z_i <= it.spz;
    set_yaw_i <= it.syaw; set_pitch_i <= it.spitch;
    do @(posedge clk_i); while (in_stall_o);
    camera_step(it, p);
    pose_q.push_back(it.fixed_exp ? RESET_POSE : p);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] sens, input logic [15:0] speed,
                            input logic fly, input unit_vec_t wup);
    logic [15:0] val [6];
    logic [2:0]  idx [6];
    val = '{sens, speed, 16'(fly), wup.x, wup.y, wup.z};
    idx = '{CFG_SENS, CFG_SPEED, CFG_FLY, CFG_WUX, CFG_WUY, CFG_WUZ};
    for (int k = 0; k < 6; k++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1; cfg_addr_i <= idx[k]; cfg_wdata_i <= val[k];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    m_sens = sens; m_speed = speed; m_fly = fly; m_wup = wup;
  endtask

  cam_req_t dir_tab [$];

  initial begin
    cam_req_t r;
    camera_reset();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_regs(16'd3932, 16'd2560, 1'b1, '{16'sd0, ONE_Q14, 16'sd0});

    // Directed table; the first two leave the reset pose untouched
    r = mk(2'd3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); r.fixed_exp = 1; dir_tab.push_back(r);
    r = mk(REQ_MOVE, 3'd6, 16'hffff, 0, 0, 1, 1, 0, 0, 0, 0, 0); r.fixed_exp = 1;
    dir_tab.push_back(r);
    dir_tab.push_back(mk(REQ_MOVE, 3'd7, 16'hffff, 0, 0, 1, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_FWD, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_BACK, 16'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_LEFT, 16'd3000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_RIGHT, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_UP, 16'd5000, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_UP, 16'd5000, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_DOWN, 16'd5000, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_DOWN, 16'd5000, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_LOOK, 0, 0, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_LOOK, 0, 0, -16'sh8000, -16'sh8000, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_LOOK, 0, 0, 16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0, 0));
    // pose loads: position extremes, yaw wrap, pitch clamp both ways
    dir_tab.push_back(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh7fffffff, 25'sh0ffffff, 24'sh7fffff));
    dir_tab.push_back(mk(REQ_MOVE, DIR_UP, 16'hffff, 0, 0, 1, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_RIGHT, 16'hffff, 0, 0, 1, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000,
                         32'sh80000000, -25'sh1000000, -24'sh800000));
    dir_tab.push_back(mk(REQ_MOVE, DIR_DOWN, 16'hffff, 0, 0, 1, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_MOVE, DIR_BACK, 16'hffff, 0, 0, 1, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 0, 0, 0, -25'sd11796480, 24'sd5832704));
    dir_tab.push_back(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 25'sd11796479, -24'sd5832704));
    dir_tab.push_back(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 25'sd5898240, 24'sd0));
    foreach (dir_tab[i]) send(dir_tab[i]);
    drain();

    // Maximum gains, no flying, world up along +x: level front parallel to it
    idle_mode = 0;
    write_regs(16'hffff, 16'hffff, 1'b0, '{ONE_Q14, 16'sd0, 16'sd0});
    send(mk(REQ_SET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 25'sd0, 24'sd0));
    send(mk(REQ_MOVE, DIR_UP, 16'hffff, 0, 0, 1, 1, 0, 0, 0, 0, 0));
    send(mk(REQ_MOVE, DIR_LEFT, 16'hffff, 0, 0, 1, 1, 0, 0, 0, 0, 0));
    for (int i = 0; i < RND_PER_PHASE; i++) begin
      if (i == 40) hold_reqs++;
      send(random_req());
    end
    drain();

    // Zero gains, extreme world up
    idle_mode = 1;
    write_regs(16'd0, 16'd0, 1'b1, '{-16'sh8000, 16'sh7fff, -16'sh8000});
    for (int i = 0; i < RND_PER_PHASE; i++) begin
      if (i == 70) drain();
      send(random_req());
    end
    drain();

    // Random registers, then back to the reset values; no idling
    idle_mode = 2;
    write_regs($urandom, $urandom, $urandom, unit_vec_t'({$urandom, $urandom}));
    for (int i = 0; i < RND_PER_PHASE; i++) send(random_req());
    drain();
    write_regs(16'd3932, 16'd2560, 1'b1, '{16'sd0, ONE_Q14, 16'sd0});
    for (int i = 0; i < RND_PER_PHASE; i++) send(random_req());
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests (moves, looks, pose loads, no-ops) and %0d poses",
             n_sent, n_got);
    $display("over 5 register settings, with stalls on both sides and a long output hold");
    if (n_err == 0 && pose_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/fpcp_pkg.sv
design/first_person_camera_pose.sv
tb/first_person_camera_pose_test.sv
